// ===== hdl/plfs_pkg.sv =====
// ----------------------------------------------------------------------------
// plfs_pkg
// Shared types and constants for the line-follow steering controller.
// ----------------------------------------------------------------------------
package plfs_pkg;

    localparam int CMD_W       = 8;
    localparam int TARGET_W    = 8;
    localparam int GAIN_W      = 16;
    localparam int STEP_W      = 7;
    localparam int PERIOD_W    = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int Q8_SHIFT    = 8;
    localparam int Q16_SHIFT   = 16;

    localparam logic signed [CMD_W-1:0] CMD_MAX = 8'sd100;
    localparam logic signed [CMD_W-1:0] CMD_MIN = -8'sd100;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_GRAY_LEVEL    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KP_Q8         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KI_DT_Q16     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KD_OVER_DT_Q8 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_PERIOD   = 3'd5;

    localparam int                  GRAY_RESET_VAL = 512;
    localparam logic [GAIN_W-1:0]   KP_RESET       = 16'd166;
    localparam logic [GAIN_W-1:0]   KI_RESET       = 16'd59;
    localparam logic [GAIN_W-1:0]   KD_RESET       = 16'd20736;
    localparam logic [STEP_W-1:0]   STEP_RESET     = 7'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 10'd50;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

    typedef struct packed {
        logic [STEP_W-1:0]   step;
        logic [PERIOD_W-1:0] period;
    } ramp_cfg_t;

endpackage

// ===== hdl/plfs_sample_if.sv =====
// ----------------------------------------------------------------------------
// plfs_sample_if
// Sensor sample channel: light reading, target speed and clear flag.
// ----------------------------------------------------------------------------
interface plfs_sample_if #(
    parameter int LIGHT_BITS = 10
);
    import plfs_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [LIGHT_BITS-1:0]      light_sample;
    logic signed [TARGET_W-1:0] target_speed;
    logic                       clear_terms;

    modport source (output valid, light_sample, target_speed, clear_terms, input ready);
    modport sink   (input valid, light_sample, target_speed, clear_terms, output ready);
endinterface

// ===== hdl/plfs_drive_if.sv =====
// ----------------------------------------------------------------------------
// plfs_drive_if
// Drive command channel: forward speed and turn command.
// ----------------------------------------------------------------------------
interface plfs_drive_if;
    import plfs_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] forward_cmd;
    logic signed [CMD_W-1:0] turn_cmd;

    modport source (output valid, forward_cmd, turn_cmd, input ready);
    modport sink   (input valid, forward_cmd, turn_cmd, output ready);
endinterface

// ===== hdl/pid_line_follow_steering.sv =====
// ----------------------------------------------------------------------------
// pid_line_follow_steering
// Line-follow PID steering with clamped turn and ramped forward speed.
// ----------------------------------------------------------------------------
// One sensor item gives one drive item. The block takes an item every clock
// cycle unless the queue is full; the front updates the error sum, last error
// and speed ramp for the item in the cycle it is accepted, so that state
// update sets the rate. A four-entry queue sits between the front and a
// three-register back end (products, Q16 accumulator, truncate/clamp output
// register), through which each result passes in that order.
// Gains are fixed point: kp and kd in Q8.8, ki times tick period in Q0.16.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only change while no items are in flight.
// ----------------------------------------------------------------------------
module pid_line_follow_steering #(
    parameter int LIGHT_BITS = 10,
    parameter int SUM_BITS   = 24
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [plfs_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [((plfs_pkg::GAIN_W > LIGHT_BITS) ?
                   plfs_pkg::GAIN_W : LIGHT_BITS)-1:0] cfg_data,
    plfs_sample_if.sink                                sensor,
    plfs_drive_if.source                               drive
);
    import plfs_pkg::*;

    localparam int ERR_W  = LIGHT_BITS + 1;
    localparam int DIFF_W = LIGHT_BITS + 2;
    localparam int Q_W    = CMD_W + ERR_W + SUM_BITS + DIFF_W;
    localparam logic [LIGHT_BITS-1:0] GRAY_RESET = LIGHT_BITS'(GRAY_RESET_VAL);

    logic [LIGHT_BITS-1:0] gray_reg;
    gains_t                gains_reg;
    ramp_cfg_t             ramp_reg;

    logic                     push_valid;
    logic                     push_ready;
    logic signed [CMD_W-1:0]  f_speed;
    logic signed [ERR_W-1:0]  f_err;
    logic signed [SUM_BITS-1:0] f_sum;
    logic signed [DIFF_W-1:0] f_diff;
    logic [Q_W-1:0]           push_data;
    logic [Q_W-1:0]           pop_data;
    logic                     pop_valid;
    logic                     pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg         <= GRAY_RESET;
            gains_reg.kp     <= KP_RESET;
            gains_reg.ki     <= KI_RESET;
            gains_reg.kd     <= KD_RESET;
            ramp_reg.step    <= STEP_RESET;
            ramp_reg.period  <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRAY_LEVEL:    gray_reg        <= cfg_data[LIGHT_BITS-1:0];
                REG_KP_Q8:         gains_reg.kp    <= cfg_data[GAIN_W-1:0];
                REG_KI_DT_Q16:     gains_reg.ki    <= cfg_data[GAIN_W-1:0];
                REG_KD_OVER_DT_Q8: gains_reg.kd    <= cfg_data[GAIN_W-1:0];
                REG_RAMP_STEP:     ramp_reg.step   <= cfg_data[STEP_W-1:0];
                REG_RAMP_PERIOD:   ramp_reg.period <= cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    plfs_front #(
        .LIGHT_BITS (LIGHT_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sensor     (sensor),
        .gray_level (gray_reg),
        .ramp       (ramp_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .speed      (f_speed),
        .err        (f_err),
        .sum        (f_sum),
        .diff       (f_diff)
    );

    assign push_data = {f_speed, f_err, f_sum, f_diff};

    plfs_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    plfs_back #(
        .LIGHT_BITS (LIGHT_BITS),
        .SUM_BITS   (SUM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .gains     (gains_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .speed     (signed'(pop_data[Q_W-1 -: CMD_W])),
        .err       (signed'(pop_data[SUM_BITS+DIFF_W +: ERR_W])),
        .sum       (signed'(pop_data[DIFF_W +: SUM_BITS])),
        .diff      (signed'(pop_data[DIFF_W-1:0])),
        .drive     (drive)
    );

endmodule

// ===== hdl/plfs_queue.sv =====
// ----------------------------------------------------------------------------
// plfs_queue
// Short FIFO between the front state update and the back multiply pipeline.
// ----------------------------------------------------------------------------
module plfs_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    import plfs_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

endmodule

// ===== hdl/plfs_front.sv =====
// ----------------------------------------------------------------------------
// plfs_front
// Takes sensor items, updates error sum, last error and speed ramp state.
// ----------------------------------------------------------------------------
module plfs_front #(
    parameter int LIGHT_BITS = 10,
    parameter int SUM_BITS   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    plfs_sample_if.sink                         sensor,
    input  logic [LIGHT_BITS-1:0]               gray_level,
    input  plfs_pkg::ramp_cfg_t                 ramp,
    output logic                                push_valid,
    input  logic                                push_ready,
    output logic signed [plfs_pkg::CMD_W-1:0]   speed,
    output logic signed [LIGHT_BITS:0]          err,
    output logic signed [SUM_BITS-1:0]          sum,
    output logic signed [LIGHT_BITS+1:0]        diff
);
    import plfs_pkg::*;

    localparam int ERR_W  = LIGHT_BITS + 1;
    localparam int DIFF_W = LIGHT_BITS + 2;

    logic signed [SUM_BITS-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0]    last_error_reg, last_error_next;
    logic [PERIOD_W-1:0]        ramp_ticks_reg, ramp_ticks_next;
    logic signed [CMD_W-1:0]    speed_reg, speed_next;

    logic                       accept;
    logic signed [CMD_W-1:0]    limit;
    logic [PERIOD_W-1:0]        ticks_inc;
    logic signed [CMD_W:0]      s_ext, lim_ext, step_ext, s_up, s_dn;
    logic signed [ERR_W-1:0]    gray_ext, light_ext, base_last;
    logic signed [SUM_BITS-1:0] base_sum;
    logic signed [SUM_BITS:0]   sum_wide;
    logic                       target_pos;

    assign accept       = sensor.valid && push_ready;
    assign sensor.ready = push_ready;
    assign push_valid   = sensor.valid;

    always_comb
    begin
        // ramp limit is the target clamped to the command range
        if (sensor.target_speed > CMD_MAX)
        begin
            limit = CMD_MAX;
        end
        else if (sensor.target_speed < CMD_MIN)
        begin
            limit = CMD_MIN;
        end
        else
        begin
            limit = sensor.target_speed;
        end

        s_ext    = (CMD_W+1)'(speed_reg);
        lim_ext  = (CMD_W+1)'(limit);
        step_ext = signed'({2'b00, ramp.step});
        s_up     = s_ext + step_ext;
        s_dn     = s_ext - step_ext;

        ticks_inc       = ramp_ticks_reg + 1'b1;
        ramp_ticks_next = ticks_inc;
        speed_next      = speed_reg;
        if (ticks_inc >= ramp.period)
        begin
            ramp_ticks_next = '0;
            if (lim_ext >= s_ext)
            begin
                speed_next = (s_up > lim_ext) ? limit : s_up[CMD_W-1:0];
            end
            else
            begin
                speed_next = (s_dn < lim_ext) ? limit : s_dn[CMD_W-1:0];
            end
        end

        base_sum  = sensor.clear_terms ? '0 : error_sum_reg;
        base_last = sensor.clear_terms ? '0 : last_error_reg;

        // zero target counts as reverse polarity
        target_pos = !sensor.target_speed[TARGET_W-1] && (sensor.target_speed != '0);
        gray_ext   = signed'({1'b0, gray_level});
        light_ext  = signed'({1'b0, sensor.light_sample});
        err        = target_pos ? (gray_ext - light_ext) : (light_ext - gray_ext);

        sum_wide = (SUM_BITS+1)'(base_sum) + (SUM_BITS+1)'(err);
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
        begin
            sum = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
        end
        else
        begin
            sum = sum_wide[SUM_BITS-1:0];
        end

        diff  = DIFF_W'(err) - DIFF_W'(base_last);
        speed = speed_next;

        error_sum_next  = sum;
        last_error_next = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            ramp_ticks_reg <= '0;
            speed_reg      <= '0;
        end
        else if (accept)
        begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= last_error_next;
            ramp_ticks_reg <= ramp_ticks_next;
            speed_reg      <= speed_next;
        end
    end

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        (speed_reg <= CMD_MAX) && (speed_reg >= CMD_MIN))
        else $error("forward speed left command range");

endmodule

// ===== hdl/plfs_back.sv =====
// ----------------------------------------------------------------------------
// plfs_back
// PID multiply, accumulate, truncate and clamp pipeline with output register.
// ----------------------------------------------------------------------------
module plfs_back #(
    parameter int LIGHT_BITS = 10,
    parameter int SUM_BITS   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  plfs_pkg::gains_t                    gains,
    input  logic                                pop_valid,
    output logic                                pop_ready,
    input  logic signed [plfs_pkg::CMD_W-1:0]   speed,
    input  logic signed [LIGHT_BITS:0]          err,
    input  logic signed [SUM_BITS-1:0]          sum,
    input  logic signed [LIGHT_BITS+1:0]        diff,
    plfs_drive_if.source                        drive
);
    import plfs_pkg::*;

    localparam int ERR_W  = LIGHT_BITS + 1;
    localparam int DIFF_W = LIGHT_BITS + 2;
    localparam int KP_W   = GAIN_W + 1 + ERR_W;
    localparam int KI_W   = GAIN_W + 1 + SUM_BITS;
    localparam int KD_W   = GAIN_W + 1 + DIFF_W;
    localparam int PD_W   = KD_W + Q8_SHIFT;
    localparam int ACC_W  = ((PD_W > KI_W) ? PD_W : KI_W) + 2;
    localparam int QUO_W  = ACC_W - Q16_SHIFT;

    logic                    s1_valid_reg;
    logic signed [KP_W-1:0]  p_kp_reg;
    logic signed [KI_W-1:0]  p_ki_reg;
    logic signed [KD_W-1:0]  p_kd_reg;
    logic signed [CMD_W-1:0] s1_speed_reg;

    logic                    s2_valid_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [CMD_W-1:0] s2_speed_reg;

    logic                    out_valid_reg;
    logic signed [CMD_W-1:0] forward_reg;
    logic signed [CMD_W-1:0] turn_reg;

    logic                    out_load;
    logic                    s2_load;
    logic                    s1_load;
    logic signed [KP_W-1:0]  p_kp;
    logic signed [KI_W-1:0]  p_ki;
    logic signed [KD_W-1:0]  p_kd;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [QUO_W-1:0] quo;
    logic signed [QUO_W:0]   neg;
    logic signed [CMD_W-1:0] turn_next;

    assign out_load  = !out_valid_reg || drive.ready;
    assign s2_load   = !s2_valid_reg || out_load;
    assign s1_load   = !s1_valid_reg || s2_load;
    assign pop_ready = s1_load;

    assign drive.valid       = out_valid_reg;
    assign drive.forward_cmd = forward_reg;
    assign drive.turn_cmd    = turn_reg;

    always_comb
    begin
        p_kp = signed'({1'b0, gains.kp}) * err;
        p_ki = signed'({1'b0, gains.ki}) * sum;
        p_kd = signed'({1'b0, gains.kd}) * diff;

        acc_next = (ACC_W'(p_kp_reg) <<< Q8_SHIFT) + ACC_W'(p_ki_reg)
                 + (ACC_W'(p_kd_reg) <<< Q8_SHIFT);

        // divide by 2^16 rounding toward zero
        quo = signed'(acc_reg[ACC_W-1:Q16_SHIFT])
            + QUO_W'(acc_reg[ACC_W-1] && (acc_reg[Q16_SHIFT-1:0] != '0));
        neg = -(QUO_W+1)'(quo);
        if (neg > (QUO_W+1)'(CMD_MAX))
        begin
            turn_next = CMD_MAX;
        end
        else if (neg < (QUO_W+1)'(CMD_MIN))
        begin
            turn_next = CMD_MIN;
        end
        else
        begin
            turn_next = neg[CMD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            p_kp_reg     <= p_kp;
            p_ki_reg     <= p_ki;
            p_kd_reg     <= p_kd;
            s1_speed_reg <= speed;
        end
        if (s2_load)
        begin
            acc_reg      <= acc_next;
            s2_speed_reg <= s1_speed_reg;
        end
        if (out_load)
        begin
            forward_reg <= s2_speed_reg;
            turn_reg    <= turn_next;
        end
    end

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((turn_reg <= CMD_MAX) && (turn_reg >= CMD_MIN)))
        else $error("turn command left command range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_load) |=> (s2_valid_reg && $stable(acc_reg)))
        else $error("accumulator stage lost an item under stall");

endmodule

// ===== tb/plfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plfs_checker
// Watches the config port and both channels of the steering controller,
// predicts each drive item from a local copy of the PID and ramp state, and
// compares accepted drive items field by field in order.
// ----------------------------------------------------------------------------
module plfs_checker #(
    parameter int LIGHT_BITS = 10,
    parameter int SUM_BITS   = 24,
    parameter int CFG_W      = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [plfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    plfs_sample_if                           sensor,
    plfs_drive_if                            drive,
    output int                               fail_count,
    output int                               pending
);
    import plfs_pkg::*;

    typedef struct packed {
        logic signed [CMD_W-1:0] forward;
        logic signed [CMD_W-1:0] turn;
    } drive_cmd_t;

    localparam longint SUM_HI = (longint'(1) <<< (SUM_BITS - 1)) - 1;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam int     MAX_REPORTS = 10;

    // register copies
    logic [LIGHT_BITS-1:0] gray;
    logic [GAIN_W-1:0]     kp;
    logic [GAIN_W-1:0]     ki;
    logic [GAIN_W-1:0]     kd;
    logic [STEP_W-1:0]     ramp_step;
    logic [PERIOD_W-1:0]   ramp_period;

    // controller state
    logic signed [SUM_BITS-1:0]   err_sum;
    logic signed [LIGHT_BITS:0]   prev_err;
    logic [PERIOD_W-1:0]          tick_cnt;
    logic signed [CMD_W-1:0]      speed;

    drive_cmd_t expected_cmds[$];
    int         mismatches = 0;

    function automatic logic signed [CMD_W-1:0] clamp_cmd(input longint v);
        if (v > longint'(CMD_MAX))
            return CMD_MAX;
        if (v < longint'(CMD_MIN))
            return CMD_MIN;
        return CMD_W'(v);
    endfunction

    function automatic void flag(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // one control tick: ramp, error, saturating sum, PID, clamp
    function automatic drive_cmd_t steer_step(input logic [LIGHT_BITS-1:0] light,
                                              input logic signed [TARGET_W-1:0] target,
                                              input logic clr);
        longint     lim;
        longint     spd;
        longint     e;
        longint     sum;
        longint     acc;
        longint     turn;
        drive_cmd_t cmd;

        lim      = clamp_cmd(target);
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= ramp_period)
        begin
            spd = speed;
            if (lim - spd >= 0)
            begin
                spd = spd + longint'(ramp_step);
                if (spd > lim)
                    spd = lim;
            end
            else
            begin
                spd = spd - longint'(ramp_step);
                if (spd < lim)
                    spd = lim;
            end
            speed    = CMD_W'(spd);
            tick_cnt = '0;
        end

        if (clr)
        begin
            err_sum  = '0;
            prev_err = '0;
        end

        // zero target counts as reverse polarity
        if (target > 0)
            e = longint'(gray) - longint'(light);
        else
            e = longint'(light) - longint'(gray);

        sum = longint'(err_sum) + e;
        if (sum > SUM_HI)
            sum = SUM_HI;
        if (sum < SUM_LO)
            sum = SUM_LO;
        err_sum = SUM_BITS'(sum);

        acc = longint'(kp) * e * 256
            + longint'(ki) * sum
            + longint'(kd) * (e - longint'(prev_err)) * 256;
        prev_err = (LIGHT_BITS + 1)'(e);

        turn = -(acc / 65536);

        cmd.forward = speed;
        cmd.turn    = clamp_cmd(turn);
        return cmd;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        drive_cmd_t want;
        if (!rst_n)
        begin
            gray        = LIGHT_BITS'(GRAY_RESET_VAL);
            kp          = KP_RESET;
            ki          = KI_RESET;
            kd          = KD_RESET;
            ramp_step   = STEP_RESET;
            ramp_period = PERIOD_RESET;
            err_sum     = '0;
            prev_err    = '0;
            tick_cnt    = '0;
            speed       = '0;
            expected_cmds.delete();
        end
        else
        begin
            if (drive.valid && drive.ready)
            begin
                if (expected_cmds.size() == 0)
                    flag($sformatf("unexpected drive item: forward %0d turn %0d",
                                   drive.forward_cmd, drive.turn_cmd));
                else
                begin
                    want = expected_cmds.pop_front();
                    if (drive.forward_cmd !== want.forward)
                        flag($sformatf("forward_cmd mismatch: expected %0d, got %0d",
                                       want.forward, drive.forward_cmd));
                    if (drive.turn_cmd !== want.turn)
                        flag($sformatf("turn_cmd mismatch: expected %0d, got %0d",
                                       want.turn, drive.turn_cmd));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRAY_LEVEL:    gray        = cfg_data[LIGHT_BITS-1:0];
                    REG_KP_Q8:         kp          = cfg_data[GAIN_W-1:0];
                    REG_KI_DT_Q16:     ki          = cfg_data[GAIN_W-1:0];
                    REG_KD_OVER_DT_Q8: kd          = cfg_data[GAIN_W-1:0];
                    REG_RAMP_STEP:     ramp_step   = cfg_data[STEP_W-1:0];
                    REG_RAMP_PERIOD:   ramp_period = cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end

            if (sensor.valid && sensor.ready)
                expected_cmds.push_back(steer_step(sensor.light_sample,
                                                   sensor.target_speed,
                                                   sensor.clear_terms));
        end
        pending    <= expected_cmds.size();
        fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the line-follow steering controller: directed
// corner items, randomized config phases with a line-tracking light walk,
// and same-sign runs that build a large error sum of either sign.
// ----------------------------------------------------------------------------
module tb_top;
    import plfs_pkg::*;

    localparam int LIGHT_BITS   = 10;
    localparam int SUM_BITS     = 24;
    localparam int CFG_W        = (GAIN_W > LIGHT_BITS) ? GAIN_W : LIGHT_BITS;
    localparam int LIGHT_TOP    = (1 << LIGHT_BITS) - 1;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SETTLE_WAIT  = 4;
    localparam int PHASE_ITEMS  = 180;
    localparam int RAIL_ITEMS   = 60;

    // indexes past the register file, writes there are dropped
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_RAMP_PERIOD + 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int gray_now    = GRAY_RESET_VAL;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;

    plfs_sample_if #(.LIGHT_BITS(LIGHT_BITS)) sensor ();
    plfs_drive_if                             drive ();

    pid_line_follow_steering #(
        .LIGHT_BITS(LIGHT_BITS),
        .SUM_BITS  (SUM_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .sensor   (sensor),
        .drive    (drive)
    );

    plfs_checker #(
        .LIGHT_BITS(LIGHT_BITS),
        .SUM_BITS  (SUM_BITS),
        .CFG_W     (CFG_W)
    ) steer_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sensor    (sensor),
        .drive     (drive),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // no item moving on either channel for too long means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sensor.valid && sensor.ready) || (drive.valid && drive.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // drive side: random backpressure plus two long hold-offs
    initial
    begin : drive_sink
        int gap;
        int taken;
        taken = 0;
        drive.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken == 100 || taken == 800)
                gap = HOLD_CYCLES;
            else
                gap = rx_idle_on ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                drive.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            drive.ready <= 1'b1;
            do
                @(posedge clk);
            while (!drive.valid);
            taken++;
        end
    end

    task automatic send_sample(input int light, input int target, input bit clr);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            sensor.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sensor.valid        <= 1'b1;
        sensor.light_sample <= LIGHT_BITS'(light);
        sensor.target_speed <= TARGET_W'(target);
        sensor.clear_terms  <= clr;
        do
            @(posedge clk);
        while (!sensor.ready);
    endtask

    // stop offering and wait until every drive item is back
    task automatic drain_all();
        sensor.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int gray, input int kp, input int ki, input int kd,
                              input int step, input int period);
        write_cfg(REG_GRAY_LEVEL, CFG_W'(gray));
        write_cfg(REG_KP_Q8, CFG_W'(kp));
        write_cfg(REG_KI_DT_Q16, CFG_W'(ki));
        write_cfg(REG_KD_OVER_DT_Q8, CFG_W'(kd));
        write_cfg(REG_RAMP_STEP, CFG_W'(step));
        write_cfg(REG_RAMP_PERIOD, CFG_W'(period));
        gray_now = gray;
    endtask

    function automatic int pick_gain();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return (1 << GAIN_W) - 1;
            2, 3:    return $urandom_range(0, (1 << GAIN_W) - 1);
            default: return $urandom_range(0, 600);
        endcase
    endfunction

    // light follows a slow walk around the gray level, with jumps and rails
    task automatic send_tracking(input int count);
        int walk;
        int light;
        int target;
        walk   = gray_now;
        target = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 4) != 0);
                rx_idle_on = ($urandom_range(0, 4) != 0);
            end
            if (i == count / 2)
                drain_all();
            if (i == 0 || $urandom_range(0, 15) == 0)
                target = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 255)) - 128
                                                     : int'($urandom_range(0, 200)) - 100;
            case ($urandom_range(0, 9))
                0: light = $urandom_range(0, LIGHT_TOP);
                1: light = $urandom_range(0, 1) ? LIGHT_TOP : 0;
                default:
                begin
                    walk = walk + int'($urandom_range(0, 40)) - 20;
                    if (walk < 0)
                        walk = 0;
                    if (walk > LIGHT_TOP)
                        walk = LIGHT_TOP;
                    light = walk;
                end
            endcase
            send_sample(light, target, $urandom_range(0, 31) == 0);
        end
    endtask

    // same-sign error for a run; the sum keeps growing in one direction
    task automatic send_rail(input int count, input int target);
        for (int i = 0; i < count; i++)
            send_sample(int'($urandom_range(0, 15)), target, 1'b0);
    endtask

    initial
    begin : stimulus
        int period;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_data            <= '0;
        sensor.valid        <= 1'b0;
        sensor.light_sample <= '0;
        sensor.target_speed <= '0;
        sensor.clear_terms  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: rails of light, polarity, out-of-range targets, clear
        send_sample(0, 100, 1'b1);
        send_sample(LIGHT_TOP, 100, 1'b0);
        send_sample(LIGHT_TOP, -100, 1'b0);
        send_sample(0, -100, 1'b0);
        send_sample(512, 127, 1'b0);
        send_sample(512, -128, 1'b0);
        send_sample(0, 0, 1'b0);
        send_sample(LIGHT_TOP, 1, 1'b0);
        send_sample(0, -1, 1'b1);
        send_sample(600, 50, 1'b0);
        drain_all();

        // ramp every tick at a step of 100, full gains
        set_config(LIGHT_TOP, 65535, 65535, 65535, 100, 0);
        send_sample(0, 127, 1'b0);
        send_sample(LIGHT_TOP, -128, 1'b0);
        send_sample(0, 30, 1'b0);
        drain_all();

        // zero step holds the speed
        write_cfg(REG_RAMP_STEP, '0);
        send_sample(200, 90, 1'b1);
        send_sample(300, -90, 1'b0);
        drain_all();

        // writes past the register file change nothing
        write_cfg(REG_SPARE_LO, '1);
        write_cfg(REG_SPARE_HI, '1);
        send_sample(LIGHT_TOP, 80, 1'b0);
        send_sample(5, -80, 1'b0);
        drain_all();

        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph == 2)
                set_config(LIGHT_TOP, 65535, 65535, 65535, 100, 1);
            else if (ph == 5)
                set_config(0, 0, 0, 0, 0, 1023);
            else
            begin
                case ($urandom_range(0, 9))
                    0:       period = 0;
                    1, 2:    period = $urandom_range(1, 1023);
                    default: period = $urandom_range(1, 4);
                endcase
                set_config($urandom_range(0, LIGHT_TOP), pick_gain(), pick_gain(), pick_gain(),
                           $urandom_range(0, 100), period);
            end
            send_tracking(PHASE_ITEMS);
            drain_all();
        end

        // error sum builds up, swings through zero to the negative side, and back
        set_config(LIGHT_TOP, 3, 256, 0, 5, 3);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_sample(0, 60, 1'b1);
        send_rail(RAIL_ITEMS, 60);
        send_rail(2 * RAIL_ITEMS, -60);
        send_rail(RAIL_ITEMS, 60);
        rx_idle_on = 1'b1;
        tx_idle_on = 1'b1;
        send_tracking(40);

        drain_all();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/plfs_pkg.sv
hdl/plfs_sample_if.sv
hdl/plfs_drive_if.sv
hdl/plfs_queue.sv
hdl/plfs_front.sv
hdl/plfs_back.sv
hdl/pid_line_follow_steering.sv
tb/plfs_checker.sv
tb/tb_top.sv
